[design/lbc_pkg.sv]
// Shared widths, fixed-point constants and the segment record for the line clipper.
// Used by every module of the clipper; depends on nothing else.
`timescale 1ns / 1ps

package lbc_pkg;

    // Field widths.
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_WIDTH = 48;
    localparam int CH_WIDTH    = 16;
    localparam int NUM_CH      = COLOR_WIDTH / CH_WIDTH;

    // Numerator and denominator of a plane test are one bit wider than a coordinate.
    localparam int NW = COORD_WIDTH + 1;
    // Quotient magnitude bits before saturation, and the signed parameter width.
    localparam int QB = FRAC_BITS + 2;
    localparam int TW = FRAC_BITS + 3;
    // Remainder width of the divider and the number of its iteration stages.
    localparam int RW         = NW + FRAC_BITS + 2;
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEPS  = (QB + DIV_STAGES - 1) / DIV_STAGES;

    // Interpolator operand and product widths.
    localparam int LW = NW;
    localparam int PW = LW + FRAC_BITS + 2;

    localparam logic signed [TW-1:0] ONE_FX = TW'(1 << FRAC_BITS);
    localparam logic signed [TW-1:0] TWO_FX = TW'(2 << FRAC_BITS);

    // One segment as it travels down the pipeline.
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] p0;
        logic [2:0][COORD_WIDTH-1:0] p1;
        logic [COLOR_WIDTH-1:0]      c0;
        logic [COLOR_WIDTH-1:0]      c1;
    } t_item;

    // Outcome of the plane tests.
    typedef struct packed {
        logic vis;
        logic clip_s;
        logic clip_e;
    } t_flags;

endpackage

[design/lbc_div.sv]
// Pipelined saturating divider: (|num| << FRAC_BITS) / |den|, signed, clamped to -2..2.
// Depends on lbc_pkg. Takes one new operand pair every cycle.
`timescale 1ns / 1ps

module lbc_div import lbc_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_den,
    output logic signed [TW-1:0] o_quot
);

    logic [NW-1:0]         r_an, r_ad, n_an, n_ad;
    logic                  r_neg, r_sat, n_sat;
    logic [RW-1:0]         r_rem [DIV_STAGES];
    logic [RW-1:0]         n_rem [DIV_STAGES];
    logic [QB-1:0]         r_q   [DIV_STAGES];
    logic [QB-1:0]         n_q   [DIV_STAGES];
    logic [NW-1:0]         r_dv  [DIV_STAGES];
    logic                  r_ng  [DIV_STAGES];
    logic                  r_st  [DIV_STAGES];
    logic signed [TW-1:0]  r_quot, n_quot;

    // Magnitudes and the early saturation check: the quotient reaches 4 when |num| >= 4|den|.
    always_comb begin
        n_an  = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_ad  = i_den[NW-1] ? NW'(-i_den) : NW'(i_den);
        n_sat = ({2'b00, n_an} >= {n_ad, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        r_an  <= n_an;
        r_ad  <= n_ad;
        r_neg <= i_num[NW-1] ^ i_den[NW-1];
        r_sat <= n_sat;
    end

    // Restoring division, DIV_STEPS quotient bits per stage.
    always_comb begin
        logic [RW-1:0] rem;
        logic [QB-1:0] q;
        logic [NW-1:0] dv;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = RW'({r_an, {FRAC_BITS{1'b0}}});
                q   = '0;
                dv  = r_ad;
            end else begin
                rem = r_rem[s-1];
                q   = r_q[s-1];
                dv  = r_dv[s-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < QB) begin
                    if (rem >= (RW'(dv) << (QB - 1 - (s * DIV_STEPS + j)))) begin
                        rem = rem - (RW'(dv) << (QB - 1 - (s * DIV_STEPS + j)));
                        q[QB - 1 - (s * DIV_STEPS + j)] = 1'b1;
                    end
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_rem[s] <= n_rem[s];
            r_q[s]   <= n_q[s];
            if (s == 0) begin
                r_dv[s] <= r_ad;
                r_ng[s] <= r_neg;
                r_st[s] <= r_sat;
            end else begin
                r_dv[s] <= r_dv[s-1];
                r_ng[s] <= r_ng[s-1];
                r_st[s] <= r_st[s-1];
            end
        end
    end

    // Clamp to two and restore the sign.
    always_comb begin
        logic signed [TW-1:0] mag;
        mag = signed'(TW'(r_q[DIV_STAGES-1]));
        if (r_st[DIV_STAGES-1] || mag > TWO_FX) begin
            mag = TWO_FX;
        end
        n_quot = r_ng[DIV_STAGES-1] ? -mag : mag;
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

[design/lbc_lerp.sv]
// Two-stage interpolator: a + round(d * t / 2^FRAC_BITS), ties away from zero.
// Depends on lbc_pkg. One multiplier, registered, then the rounding add.
`timescale 1ns / 1ps

module lbc_lerp import lbc_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [LW-1:0] i_a,
    input  logic signed [LW-1:0] i_d,
    input  logic [FRAC_BITS:0]   i_t,
    output logic signed [LW-1:0] o_val
);

    logic signed [PW-1:0] r_p;
    logic signed [LW-1:0] r_a;
    logic signed [LW-1:0] r_val, n_val;

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_d) * PW'(signed'({1'b0, i_t}));
        r_a <= i_a;
    end

    // Round the magnitude and add with the product's sign.
    always_comb begin
        logic [PW-1:0] mag;
        logic [PW-1:0] rnd;
        mag = r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
        rnd = (mag + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_val = r_p[PW-1] ? r_a - LW'(rnd) : r_a + LW'(rnd);
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

[design/line_clip_liang_barsky.sv]
// Top level of the 3D Liang-Barsky segment clipper against the cube -1..1.
// Depends on lbc_pkg, lbc_div (six plane quotients) and lbc_lerp (twelve interpolators).
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// segment   in         i_start, o_busy    i_start_x/y/z, i_end_x/y/z, i_start_color, i_end_color
// result    out        o_valid (strobe)   o_visible, o_clip_start_x/y/z, o_clip_end_x/y/z,
//                                         o_clip_start_color, o_clip_end_color
//
// One segment is taken every clock cycle. Its result passes through the input register, the
// divider, the plane-test register, the interpolators and the output register, in that order.
// o_busy stays low: the receiver cannot stall, so the pipeline never holds.
// Reset clears only the valid bits that travel with the data.

module line_clip_liang_barsky import lbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic [COLOR_WIDTH-1:0]        i_start_color,
    input  logic [COLOR_WIDTH-1:0]        i_end_color,
    output logic                          o_valid,
    output logic                          o_visible,
    output logic signed [COORD_WIDTH-1:0] o_clip_start_x,
    output logic signed [COORD_WIDTH-1:0] o_clip_start_y,
    output logic signed [COORD_WIDTH-1:0] o_clip_start_z,
    output logic signed [COORD_WIDTH-1:0] o_clip_end_x,
    output logic signed [COORD_WIDTH-1:0] o_clip_end_y,
    output logic signed [COORD_WIDTH-1:0] o_clip_end_z,
    output logic [COLOR_WIDTH-1:0]        o_clip_start_color,
    output logic [COLOR_WIDTH-1:0]        o_clip_end_color
);

    localparam int LAST = 9;

    t_item                r_item [1:LAST];
    t_item                n_item;
    logic [10:1]          r_vld;
    t_flags               r_flag [7:LAST];
    t_flags               n_flag;
    logic signed [TW-1:0] r_te, r_tl, n_te, n_tl;
    logic signed [TW-1:0] w_quot [6];
    logic signed [LW-1:0] w_s [3];
    logic signed [LW-1:0] w_e [3];
    logic signed [LW-1:0] w_cs [NUM_CH];
    logic signed [LW-1:0] w_ce [NUM_CH];

    logic                          r_o_vis;
    logic [2:0][COORD_WIDTH-1:0]   r_o_s, r_o_e, n_o_s, n_o_e;
    logic [COLOR_WIDTH-1:0]        r_o_cs, r_o_ce, n_o_cs, n_o_ce;

    assign o_busy = 1'b0;

    // Pack the input beat.
    always_comb begin
        n_item.p0 = {i_start_z, i_start_y, i_start_x};
        n_item.p1 = {i_end_z, i_end_y, i_end_x};
        n_item.c0 = i_start_color;
        n_item.c1 = i_end_color;
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:1], i_start};
        end
    end

    // Segment delay line.
    always_ff @(posedge i_clk) begin
        r_item[1] <= n_item;
        for (int k = 2; k <= LAST; k++) begin
            r_item[k] <= r_item[k-1];
        end
    end

    // Six plane quotients: lower then upper plane of each axis.
    for (genvar g = 0; g < 6; g++) begin : g_div
        logic signed [NW-1:0] w_p0, w_d, w_num, w_den;
        assign w_p0  = NW'(signed'(r_item[1].p0[g/2]));
        assign w_d   = NW'(signed'(r_item[1].p1[g/2])) - w_p0;
        assign w_num = (g % 2 == 0) ? -NW'(ONE_FX) - w_p0 : w_p0 - NW'(ONE_FX);
        assign w_den = (g % 2 == 0) ? w_d : -w_d;
        lbc_div u_div (
            .i_clk  (i_clk),
            .i_num  (w_num),
            .i_den  (w_den),
            .o_quot (w_quot[g])
        );
    end

    // Plane tests narrow the entry and leave parameters.
    always_comb begin
        logic signed [NW-1:0] p0, d, num, den;
        n_te = '0;
        n_tl = ONE_FX;
        n_flag.vis = 1'b1;
        for (int j = 0; j < 6; j++) begin
            p0  = NW'(signed'(r_item[6].p0[j/2]));
            d   = NW'(signed'(r_item[6].p1[j/2])) - p0;
            num = (j % 2 == 0) ? -NW'(ONE_FX) - p0 : p0 - NW'(ONE_FX);
            den = (j % 2 == 0) ? d : -d;
            if (den > 0) begin
                if (w_quot[j] > n_tl) begin
                    n_flag.vis = 1'b0;
                end
                if (w_quot[j] > n_te) begin
                    n_te = w_quot[j];
                end
            end else if (den < 0) begin
                if (w_quot[j] < n_te) begin
                    n_flag.vis = 1'b0;
                end
                if (w_quot[j] < n_tl) begin
                    n_tl = w_quot[j];
                end
            end else if (num > 0) begin
                n_flag.vis = 1'b0;
            end
        end
        n_flag.clip_s = n_te > 0;
        n_flag.clip_e = n_tl < ONE_FX;
    end

    always_ff @(posedge i_clk) begin
        r_te      <= n_te;
        r_tl      <= n_tl;
        r_flag[7] <= n_flag;
        for (int k = 8; k <= LAST; k++) begin
            r_flag[k] <= r_flag[k-1];
        end
    end

    // Endpoint interpolators.
    for (genvar a = 0; a < 3; a++) begin : g_pt
        logic signed [LW-1:0] w_a, w_d;
        assign w_a = LW'(signed'(r_item[7].p0[a]));
        assign w_d = LW'(signed'(r_item[7].p1[a])) - w_a;
        lbc_lerp u_s (
            .i_clk (i_clk),
            .i_a   (w_a),
            .i_d   (w_d),
            .i_t   (r_te[FRAC_BITS:0]),
            .o_val (w_s[a])
        );
        lbc_lerp u_e (
            .i_clk (i_clk),
            .i_a   (w_a),
            .i_d   (w_d),
            .i_t   (r_tl[FRAC_BITS:0]),
            .o_val (w_e[a])
        );
    end

    // Colour channel interpolators.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic signed [LW-1:0] w_a, w_d;
        assign w_a = signed'(LW'(r_item[7].c0[c*CH_WIDTH +: CH_WIDTH]));
        assign w_d = signed'(LW'(r_item[7].c1[c*CH_WIDTH +: CH_WIDTH])) - w_a;
        lbc_lerp u_s (
            .i_clk (i_clk),
            .i_a   (w_a),
            .i_d   (w_d),
            .i_t   (r_te[FRAC_BITS:0]),
            .o_val (w_cs[c])
        );
        lbc_lerp u_e (
            .i_clk (i_clk),
            .i_a   (w_a),
            .i_d   (w_d),
            .i_t   (r_tl[FRAC_BITS:0]),
            .o_val (w_ce[c])
        );
    end

    // Choose clipped or original values for the result beat.
    always_comb begin
        n_o_s  = r_item[LAST].p0;
        n_o_e  = r_item[LAST].p1;
        n_o_cs = r_item[LAST].c0;
        n_o_ce = r_item[LAST].c1;
        if (r_flag[LAST].vis && r_flag[LAST].clip_s) begin
            for (int a = 0; a < 3; a++) begin
                n_o_s[a] = w_s[a][COORD_WIDTH-1:0];
            end
            for (int c = 0; c < NUM_CH; c++) begin
                n_o_cs[c*CH_WIDTH +: CH_WIDTH] = w_cs[c][CH_WIDTH-1:0];
            end
        end
        if (r_flag[LAST].vis && r_flag[LAST].clip_e) begin
            for (int a = 0; a < 3; a++) begin
                n_o_e[a] = w_e[a][COORD_WIDTH-1:0];
            end
            for (int c = 0; c < NUM_CH; c++) begin
                n_o_ce[c*CH_WIDTH +: CH_WIDTH] = w_ce[c][CH_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_vis <= r_flag[LAST].vis;
        r_o_s   <= n_o_s;
        r_o_e   <= n_o_e;
        r_o_cs  <= n_o_cs;
        r_o_ce  <= n_o_ce;
    end

    assign o_valid            = r_vld[10];
    assign o_visible          = r_o_vis;
    assign o_clip_start_x     = r_o_s[0];
    assign o_clip_start_y     = r_o_s[1];
    assign o_clip_start_z     = r_o_s[2];
    assign o_clip_end_x       = r_o_e[0];
    assign o_clip_end_y       = r_o_e[1];
    assign o_clip_end_z       = r_o_e[2];
    assign o_clip_start_color = r_o_cs;
    assign o_clip_end_color   = r_o_ce;

endmodule
